// File: hw/rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg - shared types, constants and helpers of the complex arithmetic unit
// Operation codes, field widths, the per-cell lane record and rounding helpers.
// ----------------------------------------------------------------------------
package cau_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 15;
    localparam int CMD_W     = 3;
    localparam int IN_W      = 16;
    localparam int RES_W     = 32;

    // operation codes
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MUL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SCALE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONJ  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POW   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MAG   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_PHASE = 3'd6;
    localparam logic [CMD_W-1:0] CMD_INV   = 3'd7;

    // CORDIC: angles in Q2.30, operands scaled by 2^30
    localparam int ANG_FRAC     = 30;
    localparam int CORDIC_ITERS = 31;
    localparam int CW           = 50;
    localparam int ZW           = 34;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam int PH_SH        = ANG_FRAC - FRAC_BITS;

    // square root, one root bit per cell in the first SQRT_STEPS cells
    localparam int SQRT_STEPS = 17;
    localparam int ROOT_W     = 17;
    localparam int PW_W       = 32;

    // division: 33 quotient bits of |num| * 2^(2F+1) / power
    localparam int QUOT_W  = 33;
    localparam int DIV_SH  = 2 * FRAC_BITS + 1;
    localparam int WIDE_W  = 80;

    // pipeline shape: two front stages, the cell row, one output stage
    localparam int NUM_CELLS  = 33;
    localparam int IDX_W      = 6;
    localparam int NUM_STAGES = NUM_CELLS + 3;

    localparam int SIMPLE_W = 40;

    localparam logic signed [63:0] RES_MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] RES_MIN64 = -64'sd2147483648;

    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic signed [IN_W-1:0] a_re;
        logic signed [IN_W-1:0] a_im;
        logic signed [IN_W-1:0] b_re;
        logic signed [IN_W-1:0] b_im;
    } op_t;

    typedef struct packed {
        logic signed [RES_W-1:0] res_re;
        logic signed [RES_W-1:0] res_im;
        logic                    saturated;
        logic                    zero_divide;
    } res_t;

    // everything one item carries along the cell row
    typedef struct packed {
        logic [CMD_W-1:0]           command;
        logic [PW_W-1:0]            p;
        logic signed [SIMPLE_W-1:0] s_re;
        logic signed [SIMPLE_W-1:0] s_im;
        logic signed [CW-1:0]       x;
        logic signed [CW-1:0]       y;
        logic signed [ZW-1:0]       z;
        logic [PW_W-1:0]            sq_rem;
        logic [ROOT_W-1:0]          root;
        logic                       ovf_re;
        logic                       ovf_im;
        logic                       neg_re;
        logic                       neg_im;
        logic [PW_W-1:0]            rem_re;
        logic [PW_W-1:0]            rem_im;
        logic [QUOT_W-1:0]          quo_re;
        logic [QUOT_W-1:0]          quo_im;
        logic [QUOT_W-1:0]          nlo_re;
        logic [QUOT_W-1:0]          nlo_im;
    } lane_t;

    // arctangent of 2^-i in Q2.30
    function automatic logic signed [ZW-1:0] atan_q30(input logic [IDX_W-1:0] i);
        logic [31:0] a;
        case (i)
            6'd0:  a = 32'h3243F6A8;
            6'd1:  a = 32'h1DAC6705;
            6'd2:  a = 32'h0FADBAFC;
            6'd3:  a = 32'h07F56EA6;
            6'd4:  a = 32'h03FEAB76;
            6'd5:  a = 32'h01FFD55B;
            6'd6:  a = 32'h00FFFAAA;
            6'd7:  a = 32'h007FFF55;
            6'd8:  a = 32'h003FFFEA;
            6'd9:  a = 32'h001FFFFD;
            6'd10: a = 32'h000FFFFF;
            6'd11: a = 32'h0007FFFF;
            6'd12: a = 32'h0003FFFF;
            6'd13: a = 32'h0001FFFF;
            6'd14: a = 32'h0000FFFF;
            6'd15: a = 32'h00007FFF;
            6'd16: a = 32'h00003FFF;
            6'd17: a = 32'h00001FFF;
            6'd18: a = 32'h00000FFF;
            6'd19: a = 32'h000007FF;
            6'd20: a = 32'h000003FF;
            6'd21: a = 32'h000001FF;
            6'd22: a = 32'h000000FF;
            6'd23: a = 32'h0000007F;
            6'd24: a = 32'h0000003F;
            6'd25: a = 32'h0000001F;
            6'd26: a = 32'h0000000F;
            6'd27: a = 32'h00000008;
            6'd28: a = 32'h00000004;
            6'd29: a = 32'h00000002;
            6'd30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return signed'(ZW'(a));
    endfunction

    // round to nearest, ties away from zero
    function automatic logic signed [63:0] round_away(input logic signed [63:0] v,
                                                      input int unsigned s);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + ((64'd1 << s) >> 1)) >> s;
        return v[63] ? signed'(64'(-m)) : signed'(m);
    endfunction

    function automatic logic over32(input logic signed [63:0] v);
        return (v > RES_MAX64) || (v < RES_MIN64);
    endfunction

    function automatic logic signed [RES_W-1:0] clamp32(input logic signed [63:0] v);
        if (v > RES_MAX64)
            return RES_W'(RES_MAX64);
        else if (v < RES_MIN64)
            return RES_W'(RES_MIN64);
        else
            return RES_W'(v);
    endfunction

endpackage

// File: hw/rtl/cau_in_if.sv
// ----------------------------------------------------------------------------
// cau_in_if - operand channel
// Valid/ready channel carrying one opcode and two complex operands per item.
// ----------------------------------------------------------------------------
interface cau_in_if import cau_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic signed [IN_W-1:0] a_re;
    logic signed [IN_W-1:0] a_im;
    logic signed [IN_W-1:0] b_re;
    logic signed [IN_W-1:0] b_im;

    modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

// File: hw/rtl/cau_out_if.sv
// ----------------------------------------------------------------------------
// cau_out_if - result channel
// Valid/ready channel carrying one complex result and its flags per item.
// ----------------------------------------------------------------------------
interface cau_out_if import cau_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] res_re;
    logic signed [RES_W-1:0] res_im;
    logic                    saturated;
    logic                    zero_divide;

    modport source (output valid, res_re, res_im, saturated, zero_divide, input ready);
    modport sink   (input valid, res_re, res_im, saturated, zero_divide, output ready);
endinterface

// File: hw/rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front - product and setup stages
// Stage 0 registers the operands and their six 16x16 products; stage 1 finishes the
// short operations and prepares the CORDIC, square-root and division lanes.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
    input  logic  clk,
    input  logic  en0,
    input  logic  en1,
    input  op_t   op,
    output lane_t lane
);

    op_t                op_reg;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_aa_reg, p_bb_reg;
    lane_t              lane_reg;
    lane_t              lane_next;

    // stage 0: operands and products
    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            op_reg   <= op;
            p_rr_reg <= op.a_re * op.b_re;
            p_ii_reg <= op.a_im * op.b_im;
            p_ri_reg <= op.a_re * op.b_im;
            p_ir_reg <= op.a_im * op.b_re;
            p_aa_reg <= op.a_re * op.a_re;
            p_bb_reg <= op.a_im * op.a_im;
        end
    end

    // stage 1: short results and lane setup
    always_comb
    begin
        logic signed [IN_W-1:0] ar, ai, br, bi;
        logic [PW_W-1:0]        pw;
        logic signed [CW-1:0]   xv, yv;
        logic [IN_W-1:0]        n_re, n_im;
        logic [WIDE_W-1:0]      nw_re, nw_im, pwide;

        ar = op_reg.a_re;
        ai = op_reg.a_im;
        br = op_reg.b_re;
        bi = op_reg.b_im;
        pw = PW_W'(p_aa_reg) + PW_W'(p_bb_reg);

        lane_next         = '0;
        lane_next.command = op_reg.command;
        lane_next.p       = pw;

        // short operations
        case (op_reg.command)
            CMD_ADD:
            begin
                lane_next.s_re = SIMPLE_W'(ar) + SIMPLE_W'(br);
                lane_next.s_im = SIMPLE_W'(ai) + SIMPLE_W'(bi);
            end
            CMD_MUL:
            begin
                lane_next.s_re = SIMPLE_W'(round_away(64'(p_rr_reg) - 64'(p_ii_reg),
                                                      FRAC_BITS));
                lane_next.s_im = SIMPLE_W'(round_away(64'(p_ri_reg) + 64'(p_ir_reg),
                                                      FRAC_BITS));
            end
            CMD_SCALE:
            begin
                lane_next.s_re = SIMPLE_W'(round_away(64'(p_rr_reg), FRAC_BITS));
                lane_next.s_im = SIMPLE_W'(round_away(64'(p_ir_reg), FRAC_BITS));
            end
            CMD_CONJ:
            begin
                lane_next.s_re = SIMPLE_W'(ar);
                lane_next.s_im = -SIMPLE_W'(ai);
            end
            CMD_POW:
            begin
                lane_next.s_re = SIMPLE_W'(round_away(signed'(64'(pw)), FRAC_BITS));
                lane_next.s_im = '0;
            end
            default:
            begin
                lane_next.s_re = '0;
                lane_next.s_im = '0;
            end
        endcase

        // CORDIC start, quarter-turn prerotation for the left half-plane
        xv = CW'(ar) <<< ANG_FRAC;
        yv = CW'(ai) <<< ANG_FRAC;
        if (ar < 0)
        begin
            if (ai >= 0)
            begin
                lane_next.x = yv;
                lane_next.y = -xv;
                lane_next.z = HALF_PI_Q30;
            end
            else
            begin
                lane_next.x = -yv;
                lane_next.y = xv;
                lane_next.z = -HALF_PI_Q30;
            end
        end
        else
        begin
            lane_next.x = xv;
            lane_next.y = yv;
            lane_next.z = '0;
        end

        // square root start
        lane_next.sq_rem = pw;
        lane_next.root   = '0;

        // division start: overflow check, high remainder and low dividend bits
        n_re  = ar[IN_W-1] ? IN_W'(-ar) : IN_W'(ar);
        n_im  = ai[IN_W-1] ? IN_W'(-ai) : IN_W'(ai);
        nw_re = WIDE_W'(n_re) << DIV_SH;
        nw_im = WIDE_W'(n_im) << DIV_SH;
        pwide = WIDE_W'(pw) << QUOT_W;
        lane_next.ovf_re = nw_re >= pwide;
        lane_next.ovf_im = nw_im >= pwide;
        lane_next.neg_re = ar < 0;
        lane_next.neg_im = ai > 0;
        lane_next.rem_re = nw_re[QUOT_W +: PW_W];
        lane_next.rem_im = nw_im[QUOT_W +: PW_W];
        lane_next.quo_re = '0;
        lane_next.quo_im = '0;
        lane_next.nlo_re = nw_re[QUOT_W-1:0];
        lane_next.nlo_im = nw_im[QUOT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            lane_reg <= lane_next;
    end

    assign lane = lane_reg;

endmodule

// File: hw/rtl/cau_cell.sv
// ----------------------------------------------------------------------------
// cau_cell - one cell of the iteration row
// CORDIC rotation if idx < CORDIC_ITERS, square-root bit if idx < SQRT_STEPS,
// one quotient bit for each of the two divisions, then a register onwards.
// ----------------------------------------------------------------------------
module cau_cell import cau_pkg::*; (
    input  logic             clk,
    input  logic             en,
    input  logic [IDX_W-1:0] idx,
    input  lane_t            d,
    output lane_t            q
);

    lane_t lane_reg;
    lane_t lane_next;

    // restoring division step: returns {remainder, quotient bit}
    function automatic logic [PW_W:0] div_step(input logic [PW_W-1:0] rem,
                                                input logic            nbit,
                                                input logic [PW_W-1:0] p);
        logic [PW_W:0] r2;
        logic          ge;
        r2 = {rem, nbit};
        ge = r2 >= {1'b0, p};
        return ge ? {PW_W'(r2 - {1'b0, p}), 1'b1} : {r2[PW_W-1:0], 1'b0};
    endfunction

    always_comb
    begin
        logic signed [CW-1:0] dx, dy;
        logic signed [ZW-1:0] ang;
        logic [IDX_W-1:0]     b;
        logic [PW_W+2:0]      dd;
        logic [PW_W:0]        st_re, st_im;

        lane_next = d;

        // CORDIC vectoring rotation
        dx  = d.y >>> idx;
        dy  = d.x >>> idx;
        ang = atan_q30(idx);
        if (idx < IDX_W'(CORDIC_ITERS))
        begin
            if (!d.y[CW-1])
            begin
                lane_next.x = d.x + dx;
                lane_next.y = d.y - dy;
                lane_next.z = d.z + ang;
            end
            else
            begin
                lane_next.x = d.x - dx;
                lane_next.y = d.y + dy;
                lane_next.z = d.z - ang;
            end
        end

        // square root: try root bit b against the running remainder
        b  = IDX_W'(SQRT_STEPS - 1) - idx;
        dd = ((PW_W+3)'(d.root) << (b + 1'b1)) + ((PW_W+3)'(1) << {b, 1'b0});
        if (idx < IDX_W'(SQRT_STEPS))
        begin
            if (dd <= (PW_W+3)'(d.sq_rem))
            begin
                lane_next.sq_rem = PW_W'((PW_W+3)'(d.sq_rem) - dd);
                lane_next.root   = d.root | (ROOT_W'(1) << b);
            end
        end

        // one quotient bit for each part
        st_re = div_step(d.rem_re, d.nlo_re[QUOT_W-1], d.p);
        st_im = div_step(d.rem_im, d.nlo_im[QUOT_W-1], d.p);
        lane_next.rem_re = st_re[PW_W:1];
        lane_next.rem_im = st_im[PW_W:1];
        lane_next.quo_re = {d.quo_re[QUOT_W-2:0], st_re[0]};
        lane_next.quo_im = {d.quo_im[QUOT_W-2:0], st_im[0]};
        lane_next.nlo_re = d.nlo_re << 1;
        lane_next.nlo_im = d.nlo_im << 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign q = lane_reg;

endmodule

// File: hw/rtl/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back - result stage
// Rounds the iterated results, selects by opcode, clamps to 32 bits and holds
// the result item in the output register.
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; (
    input  logic  clk,
    input  logic  en,
    input  lane_t d,
    output res_t  res
);

    res_t res_reg;
    res_t res_next;

    always_comb
    begin
        logic signed [63:0] re, im, phase, mag, inv_re, inv_im;
        logic [QUOT_W:0]    qr_re, qr_im;
        logic               zd;

        // phase: round the Q2.30 angle; zero vector has phase zero
        phase = (d.p == '0) ? 64'sd0 : round_away(64'(d.z), PH_SH);

        // magnitude: round the integer root
        mag = signed'(64'(d.root) + 64'(d.sq_rem > PW_W'(d.root)));

        // inverse: round the quotient, apply sign, force overflow
        qr_re  = ((QUOT_W+1)'(d.quo_re) + 1'b1) >> 1;
        qr_im  = ((QUOT_W+1)'(d.quo_im) + 1'b1) >> 1;
        inv_re = d.neg_re ? -signed'(64'(qr_re)) : signed'(64'(qr_re));
        inv_im = d.neg_im ? -signed'(64'(qr_im)) : signed'(64'(qr_im));
        if (d.ovf_re)
            inv_re = d.neg_re ? -(64'sd1 <<< 40) : (64'sd1 <<< 40);
        if (d.ovf_im)
            inv_im = d.neg_im ? -(64'sd1 <<< 40) : (64'sd1 <<< 40);

        zd = 1'b0;
        case (d.command)
            CMD_MAG:
            begin
                re = mag;
                im = '0;
            end
            CMD_PHASE:
            begin
                re = phase;
                im = '0;
            end
            CMD_INV:
            begin
                if (d.p == '0)
                begin
                    zd = 1'b1;
                    re = '0;
                    im = '0;
                end
                else
                begin
                    re = inv_re;
                    im = inv_im;
                end
            end
            default:
            begin
                re = 64'(d.s_re);
                im = 64'(d.s_im);
            end
        endcase

        res_next.res_re      = clamp32(re);
        res_next.res_im      = clamp32(im);
        res_next.saturated   = over32(re) | over32(im);
        res_next.zero_divide = zd;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// File: hw/rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit - pipelined fixed-point complex ALU
// Add, multiply, scale, conjugate, power, magnitude, phase and inverse on
// Q1.15 operands, results in Q17.15 with saturation and zero-divide flags.
//
// Usage:
//   operand (sink): opcode plus a and b, one item per valid/ready handshake.
//   result  (source): res_re, res_im, saturated, zero_divide.
//   An accepted item enters a product stage at the accepting edge, then
//   passes a setup stage, a row of 33 cells and an output register. Every
//   operation takes the same path, so items leave in the order they came.
//   Throughput is one item per cycle while the receiver takes results; the
//   row of cells is the pipeline, each cell doing one quotient bit per
//   division and, in the leading cells, one CORDIC rotation and one root bit.
//   Each stage holds a valid bit and moves on when the stage after it is
//   empty or moving, so a stalled receiver stops only the full stages in
//   front of it and empty slots further back still fill with new items.
//   Reset (rst_n low, asynchronous) empties every stage; there is no
//   other state and no clearing pass.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    cau_in_if.sink  operand,
    cau_out_if.source result
);

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES:0]   en;
    op_t                   op;
    lane_t                 lane [0:NUM_CELLS];
    res_t                  res;

    // stage advance: a stage moves when empty or when its successor moves
    always_comb
    begin
        en[NUM_STAGES] = result.ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    // valid bits follow the data
    always_comb
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (en[k])
                v_next[k] = (k == 0) ? operand.valid : v_reg[(k == 0) ? 0 : k - 1];
            else
                v_next[k] = v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign operand.ready = en[0];

    assign op.command = operand.command;
    assign op.a_re    = operand.a_re;
    assign op.a_im    = operand.a_im;
    assign op.b_re    = operand.b_re;
    assign op.b_im    = operand.b_im;

    cau_front u_front (
        .clk  (clk),
        .en0  (en[0]),
        .en1  (en[1]),
        .op   (op),
        .lane (lane[0])
    );

    // row of iteration cells
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        cau_cell u_cell (
            .clk (clk),
            .en  (en[k+2]),
            .idx (IDX_W'(k)),
            .d   (lane[k]),
            .q   (lane[k+1])
        );
    end

    cau_back u_back (
        .clk (clk),
        .en  (en[NUM_STAGES-1]),
        .d   (lane[NUM_CELLS]),
        .res (res)
    );

    assign result.valid       = v_reg[NUM_STAGES-1];
    assign result.res_re      = res.res_re;
    assign result.res_im      = res.res_im;
    assign result.saturated   = res.saturated;
    assign result.zero_divide = res.zero_divide;

    // a zero divide returns zero and never flags saturation
    a_zero_divide: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.zero_divide |->
            !result.saturated && result.res_re == 0 && result.res_im == 0)
        else $error("zero divide result not clean");

    // a receiver that takes the result frees the whole row
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        result.ready |-> operand.ready)
        else $error("input stalled while output drains");

    // input refused only when the first stage is occupied
    a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
        !operand.ready |-> v_reg[0])
        else $error("input refused with empty first stage");

    // a held first stage keeps its item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && !en[1] |=> v_reg[0])
        else $error("item lost in first stage");

endmodule
